// ===== hw/rtl/cba_pkg.sv =====
// Shared types and codes of the contiguous block allocator.
package cba_pkg;

   // Request codes
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_EXTEND = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXISTS    = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_NO_SPACE  = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // Reset value of the disk size register
   localparam logic [6:0] DISK_BLOCKS_RESET = 7'd64;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] file_number;
      logic [6:0] block_count;
   } cba_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] start_block;
      logic [6:0] file_blocks;
   } cba_rsp_type;

   // Control of the rotating block map
   typedef struct packed {
      logic shift;
      logic wr;
      logic wr_bit;
   } cba_map_ctrl_type;

   // Control of the directory
   typedef struct packed {
      logic rd;
      logic wr;
      logic set_valid;
      logic clr_valid;
   } cba_dir_cmd_type;

endpackage

// ===== hw/rtl/cba_block_map.sv =====
// Used/free map of disk blocks held in a rotating shift register.
module cba_block_map #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cba_pkg::cba_map_ctrl_type     ctrl,
   output logic                          head,
   output logic [$clog2(MAX_BLOCKS)-1:0] pos,
   output logic                          last
);

   localparam int AW = $clog2(MAX_BLOCKS);

   logic [MAX_BLOCKS-1:0] map_ff, map_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic                  last_pos;

   assign last_pos = (pos_ff == AW'(MAX_BLOCKS - 1));
   assign head     = map_ff[0];
   assign pos      = pos_ff;
   assign last     = last_pos;

   // Rotate one block per cycle while shift is high; the head bit may be rewritten as it passes
   always_comb begin
      map_in = map_ff;
      pos_in = pos_ff;
      if (ctrl.shift) begin
         map_in = {(ctrl.wr ? ctrl.wr_bit : map_ff[0]), map_ff[MAX_BLOCKS-1:1]};
         pos_in = last_pos ? '0 : pos_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
         pos_ff <= '0;
      end else begin
         map_ff <= map_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hw/rtl/cba_directory.sv =====
// File directory: valid bits plus start and size memory indexed by file number.
module cba_directory #(
   parameter int MAX_FILES = 16,
   parameter int AW        = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cba_pkg::cba_dir_cmd_type     cmd,
   input  logic [$clog2(MAX_FILES)-1:0] rd_idx,
   input  logic [$clog2(MAX_FILES)-1:0] wr_idx,
   input  logic [AW-1:0]                wr_start,
   input  logic [6:0]                   wr_size,
   output logic [AW-1:0]                rd_start,
   output logic [6:0]                   rd_size,
   output logic [MAX_FILES-1:0]         valid
);

   logic [AW-1:0]        start_mem_ff [MAX_FILES];
   logic [6:0]           size_mem_ff  [MAX_FILES];
   logic [AW-1:0]        rd_start_ff;
   logic [6:0]           rd_size_ff;
   logic [MAX_FILES-1:0] valid_ff, valid_in;

   assign rd_start = rd_start_ff;
   assign rd_size  = rd_size_ff;
   assign valid    = valid_ff;

   // Write and registered read of the entry memory
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         start_mem_ff[wr_idx] <= wr_start;
         size_mem_ff[wr_idx]  <= wr_size;
      end
      if (cmd.rd) begin
         rd_start_ff <= start_mem_ff[rd_idx];
         rd_size_ff  <= size_mem_ff[rd_idx];
      end
   end

   // Set or drop the valid bit of the written slot
   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) valid_in[wr_idx] = 1'b1;
      if (cmd.clr_valid) valid_in[wr_idx] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/contiguous_block_allocator.sv =====
// First-fit contiguous block allocator, top level.
//
// Requests (create, delete, extend) enter on req_data when start is high and
// busy is low. Each request gives exactly one response beat: rsp_valid is high
// for one cycle with rsp_data, and the receiver must take it then; it cannot
// stall. csr_we with csr_wdata writes the disk size register (reset 64); write
// it only while busy is low and no response is pending.
//
// The block map is a shift register that rotates one block per cycle while
// a search or marking pass runs, and each pass goes once around the map.
// Create and extend make a search pass and a marking pass; delete makes the
// marking pass only. Refusals are found either on the directory lookup or
// by the search. busy is low in the cycle of the response beat, so the next
// request can be taken at the same edge that takes the beat.
//
// Reset clears the block map and the directory valid bits at once; the block
// is ready in the first cycle after reset.
module contiguous_block_allocator #(
   parameter int MAX_BLOCKS = 64,
   parameter int MAX_FILES  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cba_pkg::cba_req_type req_data,
   output logic                 rsp_valid,
   output cba_pkg::cba_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata
);

   localparam int AW  = $clog2(MAX_BLOCKS);
   localparam int W   = ((AW > 7) ? AW : 7) + 2;
   localparam int FW  = $clog2(MAX_FILES);
   localparam int FIW = ((FW > 4) ? FW : 4) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_CHECK,
      S_MARK
   } state_type;

   state_type            state_ff, state_in;
   cba_pkg::cba_req_type req_ff, req_in;
   logic [6:0]           disk_blocks_ff, disk_blocks_in;
   logic                 found_ff, found_in;
   logic [6:0]           run_ff, run_in;
   logic                 hit_ff, hit_in;
   logic [W-1:0]         first_ff, first_in;
   logic [6:0]           len_ff, len_in;
   logic                 val_ff, val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cba_pkg::cba_rsp_type rsp_ff, rsp_in;

   cba_pkg::cba_map_ctrl_type map_ctrl;
   cba_pkg::cba_dir_cmd_type  dir_cmd;
   logic                      head;
   logic [AW-1:0]             pos;
   logic                      last;
   logic [AW-1:0]             dir_rd_start;
   logic [6:0]                dir_rd_size;
   logic [MAX_FILES-1:0]      dir_valid;

   logic [FIW-1:0] acc_fn_w, fn_w;
   logic [FW-1:0]  acc_idx, fn_idx;
   logic           slot_ok, slot_valid;
   logic [W-1:0]   pos_w, disk_w, cnt_w, end_w, db_w, mb_w;
   logic           in_disk, finish;

   function automatic cba_pkg::cba_rsp_type fail_rsp(input logic [2:0] code);
      cba_pkg::cba_rsp_type r;
      r.status      = code;
      r.start_block = '0;
      r.file_blocks = '0;
      return r;
   endfunction

   // Slot decode
   assign acc_fn_w   = FIW'(req_data.file_number);
   assign acc_idx    = acc_fn_w[FW-1:0];
   assign fn_w       = FIW'(req_ff.file_number);
   assign fn_idx     = fn_w[FW-1:0];
   assign slot_ok    = (fn_w < FIW'(MAX_FILES));
   assign slot_valid = dir_valid[fn_idx];

   // Wide arithmetic domain for block positions
   assign pos_w   = W'(pos);
   assign db_w    = W'(disk_blocks_ff);
   assign mb_w    = W'(MAX_BLOCKS);
   assign disk_w  = (db_w < mb_w) ? db_w : mb_w;
   assign cnt_w   = W'(req_ff.block_count);
   assign end_w   = W'(dir_rd_start) + W'(dir_rd_size);
   assign in_disk = (pos_w < disk_w);
   assign finish  = (state_ff == S_MARK) && last;

   // Map control: rotate during both passes, rewrite inside the marked run
   always_comb begin
      map_ctrl.shift  = (state_ff == S_SCAN) || (state_ff == S_MARK);
      map_ctrl.wr     = (state_ff == S_MARK) && (pos_w >= first_ff) &&
                        (pos_w < first_ff + W'(len_ff));
      map_ctrl.wr_bit = val_ff;
   end

   // Directory control: read at accept, update at the end of the marking pass
   always_comb begin
      dir_cmd.rd        = (state_ff == S_IDLE) && start;
      dir_cmd.wr        = finish && ((req_ff.req_type == cba_pkg::REQ_CREATE) ||
                                     (req_ff.req_type == cba_pkg::REQ_EXTEND));
      dir_cmd.set_valid = finish && (req_ff.req_type == cba_pkg::REQ_CREATE);
      dir_cmd.clr_valid = finish && (req_ff.req_type == cba_pkg::REQ_DELETE);
   end

   cba_block_map #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .ctrl  (map_ctrl),
      .head  (head),
      .pos   (pos),
      .last  (last)
   );

   cba_directory #(
      .MAX_FILES (MAX_FILES),
      .AW        (AW)
   ) u_dir (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dir_cmd),
      .rd_idx   (acc_idx),
      .wr_idx   (fn_idx),
      .wr_start ((req_ff.req_type == cba_pkg::REQ_CREATE) ?
                 first_ff[AW-1:0] : dir_rd_start),
      .wr_size  ((req_ff.req_type == cba_pkg::REQ_CREATE) ?
                 req_ff.block_count : dir_rd_size + req_ff.block_count),
      .rd_start (dir_rd_start),
      .rd_size  (dir_rd_size),
      .valid    (dir_valid)
   );

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      disk_blocks_in = disk_blocks_ff;
      found_in       = found_ff;
      run_in         = run_ff;
      hit_in         = hit_ff;
      first_in       = first_ff;
      len_in         = len_ff;
      val_in         = val_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;

      if (csr_we) disk_blocks_in = csr_wdata;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DECIDE;
            end
         end

         // Check the slot against the directory and the create size against the disk size
         S_DECIDE: begin
            unique case (req_ff.req_type)
               cba_pkg::REQ_CREATE: begin
                  if (!slot_ok) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = fail_rsp(cba_pkg::ST_NOT_FOUND);
                     state_in     = S_IDLE;
                  end else if (slot_valid) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = fail_rsp(cba_pkg::ST_EXISTS);
                     state_in     = S_IDLE;
                  end else if ((req_ff.block_count == 7'd0) || (cnt_w > disk_w)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = fail_rsp(cba_pkg::ST_BAD_SIZE);
                     state_in     = S_IDLE;
                  end else begin
                     found_in = 1'b0;
                     run_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               cba_pkg::REQ_DELETE: begin
                  if (slot_ok && slot_valid) begin
                     first_in = W'(dir_rd_start);
                     len_in   = dir_rd_size;
                     val_in   = 1'b0;
                     state_in = S_MARK;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = fail_rsp(cba_pkg::ST_NOT_FOUND);
                     state_in     = S_IDLE;
                  end
               end
               cba_pkg::REQ_EXTEND: begin
                  if (slot_ok && slot_valid) begin
                     hit_in   = 1'b0;
                     state_in = S_SCAN;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = fail_rsp(cba_pkg::ST_NOT_FOUND);
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = fail_rsp(cba_pkg::ST_NOT_FOUND);
                  state_in     = S_IDLE;
               end
            endcase
         end

         // Search pass: count free runs for create, look for used blocks for extend
         S_SCAN: begin
            if (req_ff.req_type == cba_pkg::REQ_CREATE) begin
               if (!found_ff) begin
                  if (in_disk && !head) begin
                     if (run_ff + 7'd1 == req_ff.block_count) begin
                        found_in = 1'b1;
                        first_in = pos_w - cnt_w + W'(1);
                     end else begin
                        run_in = run_ff + 7'd1;
                     end
                  end else begin
                     run_in = '0;
                  end
               end
            end else begin
               if (head && (pos_w >= end_w) && (pos_w < end_w + cnt_w)) hit_in = 1'b1;
            end
            if (last) state_in = S_CHECK;
         end

         // Decide whether to mark
         S_CHECK: begin
            if (req_ff.req_type == cba_pkg::REQ_CREATE) begin
               if (found_ff) begin
                  len_in   = req_ff.block_count;
                  val_in   = 1'b1;
                  state_in = S_MARK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = fail_rsp(cba_pkg::ST_NO_SPACE);
                  state_in     = S_IDLE;
               end
            end else begin
               if ((end_w + cnt_w > disk_w) || hit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = fail_rsp(cba_pkg::ST_NO_SPACE);
                  state_in     = S_IDLE;
               end else begin
                  first_in = end_w;
                  len_in   = req_ff.block_count;
                  val_in   = 1'b1;
                  state_in = S_MARK;
               end
            end
         end

         // Marking pass; send the response beat when the map is back in place
         S_MARK: begin
            if (last) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               rsp_in       = fail_rsp(cba_pkg::ST_OK);
               if (req_ff.req_type == cba_pkg::REQ_CREATE) begin
                  rsp_in.start_block = first_ff[5:0];
                  rsp_in.file_blocks = req_ff.block_count;
               end else if (req_ff.req_type == cba_pkg::REQ_EXTEND) begin
                  rsp_in.start_block = 6'(dir_rd_start);
                  rsp_in.file_blocks = dir_rd_size + req_ff.block_count;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         disk_blocks_ff <= cba_pkg::DISK_BLOCKS_RESET;
         rsp_valid_ff   <= 1'b0;
         found_ff       <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         disk_blocks_ff <= disk_blocks_in;
         rsp_valid_ff   <= rsp_valid_in;
         found_ff       <= found_in;
         hit_ff         <= hit_in;
      end
      req_ff   <= req_in;
      run_ff   <= run_in;
      first_ff <= first_in;
      len_ff   <= len_in;
      val_ff   <= val_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/cba_checker.sv =====
// Port-level checks of the contiguous block allocator and their binding.
module cba_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input cba_pkg::cba_rsp_type rsp_data,
   input logic                 rsp_valid
);

   // Come out of reset idle with no response beat
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // Go busy after taking a request
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // Send exactly one beat per response
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // Release busy with the response beat
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while a response beat is shown");

   // Zero the start and size on any refusal
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != cba_pkg::ST_OK) |->
      (rsp_data.start_block == 6'd0) && (rsp_data.file_blocks == 7'd0))
      else $error("refused request returned a nonzero start or size");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

// ===== test/tb_contiguous_block_allocator.sv =====
// Self-checking testbench of the first-fit contiguous block allocator.
`default_nettype none

module tb_contiguous_block_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCKS   = 64;
   localparam int MAX_FILES    = 16;
   localparam int SETTLE       = 4;
   localparam int TAIL_CYCLES  = 2 * MAX_BLOCKS + 40;
   localparam int CYCLE_LIMIT  = 1000000;

   // Request code that the block does not define
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   // Kinds of work queued for the driver
   typedef enum logic [1:0] {
      OP_REQ,
      OP_CFG,
      OP_DRAIN
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      cba_pkg::cba_req_type req;
      logic [6:0]           value;
      logic                 calm;
   } disk_op_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   cba_pkg::cba_req_type req_data = '0;
   logic                 rsp_valid;
   cba_pkg::cba_rsp_type rsp_data;
   logic                 csr_we = 1'b0;
   logic [6:0]           csr_wdata = '0;

   disk_op_type          op_q[$];
   cba_pkg::cba_rsp_type answer_q[$];
   int                   mismatches = 0;
   int                   cycle_count = 0;
   int                   gap_left = 0;
   int                   settle_cnt = 0;

   // Shadow of the allocator state
   bit          blk_used [MAX_BLOCKS];
   bit          file_ok [MAX_FILES];
   int          file_start [MAX_FILES];
   int          file_size [MAX_FILES];
   logic [6:0]  disk_cfg;

   contiguous_block_allocator #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .MAX_FILES (MAX_FILES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic bit span_free(int first, int cnt);
      for (int i = 0; i < cnt; i++) begin
         if (first + i >= MAX_BLOCKS || blk_used[first + i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void span_mark(int first, int cnt, bit val);
      for (int i = 0; i < cnt; i++) begin
         if (first + i < MAX_BLOCKS) begin
            blk_used[first + i] = val;
         end
      end
   endfunction

   // Apply one request to the shadow state and return the answer it gives
   function automatic cba_pkg::cba_rsp_type predict_answer(cba_pkg::cba_req_type rq);
      int                   disk;
      int                   cnt;
      int                   fn;
      int                   tail;
      int                   s;
      bit                   found;
      cba_pkg::cba_rsp_type ans;
      disk  = (disk_cfg < MAX_BLOCKS) ? int'(disk_cfg) : MAX_BLOCKS;
      cnt   = int'(rq.block_count);
      fn    = int'(rq.file_number);
      found = 1'b0;
      ans.status      = cba_pkg::ST_NOT_FOUND;
      ans.start_block = '0;
      ans.file_blocks = '0;
      case (rq.req_type)
         cba_pkg::REQ_CREATE: begin
            if (file_ok[fn]) begin
               ans.status = cba_pkg::ST_EXISTS;
            end else if (cnt == 0 || cnt > disk) begin
               ans.status = cba_pkg::ST_BAD_SIZE;
            end else begin
               ans.status = cba_pkg::ST_NO_SPACE;
               // first fit: lowest start with a free run
               for (s = 0; s + cnt <= disk && !found; s++) begin
                  if (span_free(s, cnt)) begin
                     found = 1'b1;
                     span_mark(s, cnt, 1'b1);
                     file_ok[fn]     = 1'b1;
                     file_start[fn]  = s;
                     file_size[fn]   = cnt;
                     ans.status      = cba_pkg::ST_OK;
                     ans.start_block = 6'(s);
                     ans.file_blocks = 7'(cnt);
                  end
               end
            end
         end
         cba_pkg::REQ_DELETE: begin
            if (file_ok[fn]) begin
               span_mark(file_start[fn], file_size[fn], 1'b0);
               file_ok[fn] = 1'b0;
               ans.status  = cba_pkg::ST_OK;
            end
         end
         cba_pkg::REQ_EXTEND: begin
            if (file_ok[fn]) begin
               tail = file_start[fn] + file_size[fn];
               if (tail + cnt > disk || !span_free(tail, cnt)) begin
                  ans.status = cba_pkg::ST_NO_SPACE;
               end else begin
                  span_mark(tail, cnt, 1'b1);
                  file_size[fn]   = file_size[fn] + cnt;
                  ans.status      = cba_pkg::ST_OK;
                  ans.start_block = 6'(file_start[fn]);
                  ans.file_blocks = 7'(file_size[fn]);
               end
            end
         end
         default: begin
            ans.status = cba_pkg::ST_NOT_FOUND;
         end
      endcase
      return ans;
   endfunction

   task automatic add_req(logic [1:0] t, int fn, int cnt, logic calm);
      disk_op_type op;
      op.kind            = OP_REQ;
      op.req.req_type    = t;
      op.req.file_number = 4'(fn);
      op.req.block_count = 7'(cnt);
      op.value           = '0;
      op.calm            = calm;
      op_q = {op_q, op};
   endtask

   task automatic add_cfg(int value);
      disk_op_type op;
      op       = '0;
      op.kind  = OP_CFG;
      op.value = 7'(value);
      op_q = {op_q, op};
   endtask

   task automatic add_drain();
      disk_op_type op;
      op      = '0;
      op.kind = OP_DRAIN;
      op_q = {op_q, op};
   endtask

   // Drive requests and register writes from the work queue
   always @(posedge clock) begin : drive
      disk_op_type          head;
      logic                 nxt_start;
      cba_pkg::cba_req_type nxt_data;
      logic                 nxt_we;
      logic [6:0]           nxt_wd;
      nxt_start = 1'b0;
      nxt_data  = req_data;
      nxt_we    = 1'b0;
      nxt_wd    = csr_wdata;
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_used[i] = 1'b0;
         end
         for (int i = 0; i < MAX_FILES; i++) begin
            file_ok[i]    = 1'b0;
            file_start[i] = 0;
            file_size[i]  = 0;
         end
         disk_cfg   = cba_pkg::DISK_BLOCKS_RESET;
         gap_left   = 0;
         settle_cnt = 0;
      end else begin
         // accepted beat: predict its answer, maybe open a gap
         if (start === 1'b1 && busy === 1'b0) begin
            head = op_q.pop_front();
            answer_q = {answer_q, predict_answer(head.req)};
            if (!head.calm && $urandom_range(0, 2) == 0) begin
               gap_left = $urandom_range(1, 13);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (op_q.size() != 0) begin
            head = op_q[0];
            case (head.kind)
               OP_REQ: begin
                  nxt_start = 1'b1;
                  nxt_data  = head.req;
               end
               OP_DRAIN: begin
                  if (answer_q.size() == 0) begin
                     void'(op_q.pop_front());
                  end
               end
               OP_CFG: begin
                  // write only once no answer is outstanding and the settle counter has run out
                  if (answer_q.size() != 0) begin
                     settle_cnt = 0;
                  end else if (settle_cnt < SETTLE) begin
                     settle_cnt++;
                  end else begin
                     nxt_we     = 1'b1;
                     nxt_wd     = head.value;
                     disk_cfg   = head.value;
                     settle_cnt = 0;
                     void'(op_q.pop_front());
                  end
               end
               default: begin
                  void'(op_q.pop_front());
               end
            endcase
         end
      end
      start     <= nxt_start;
      req_data  <= nxt_data;
      csr_we    <= nxt_we;
      csr_wdata <= nxt_wd;
   end

   // Check each response beat against the oldest predicted answer
   always @(posedge clock) begin : watch
      cba_pkg::cba_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (answer_q.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            end
            if (rsp_data.start_block !== want.start_block) begin
               report_mismatch($sformatf("start_block %0d, want %0d",
                                         rsp_data.start_block, want.start_block));
            end
            if (rsp_data.file_blocks !== want.file_blocks) begin
               report_mismatch($sformatf("file_blocks %0d, want %0d",
                                         rsp_data.file_blocks, want.file_blocks));
            end
         end
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : sequence_run
      int phase_disk [12];
      int per_phase;
      int total;
      int issued;
      int k;
      int r;
      int fn;
      int cnt;
      logic [1:0] t;
      logic calm;
      phase_disk = '{64, 1, 127, 0, 16, 64, 5, 37, 64, 2, 0, 0};
      phase_disk[10] = $urandom_range(1, 64);
      phase_disk[11] = $urandom_range(1, 64);
      per_phase = 105;
      total     = 12 * per_phase;
      issued    = 0;
      calm      = 1'b0;

      // directed: size limits, every request, every refusal
      add_req(cba_pkg::REQ_CREATE, 0, 0, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 0, 64, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 1, 1, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 0, 0, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 0, 1, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 0, 5, 1'b0);
      add_req(cba_pkg::REQ_DELETE, 0, 0, 1'b0);
      add_req(cba_pkg::REQ_DELETE, 0, 127, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 15, 3, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 15, 65, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 15, 127, 1'b0);
      add_req(REQ_RESERVED, 7, 127, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 1, 3, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 2, 4, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 3, 2, 1'b0);
      add_req(cba_pkg::REQ_DELETE, 2, 0, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 4, 2, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 1, 1, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 4, 2, 1'b0);
      add_req(cba_pkg::REQ_EXTEND, 3, 55, 1'b0);
      add_req(cba_pkg::REQ_CREATE, 5, 1, 1'b0);
      add_drain();
      add_req(cba_pkg::REQ_DELETE, 1, 0, 1'b0);
      add_req(cba_pkg::REQ_DELETE, 3, 0, 1'b0);
      add_req(cba_pkg::REQ_DELETE, 4, 0, 1'b0);

      // random phases, each under its own disk size
      for (int p = 0; p < 12; p++) begin
         add_cfg(phase_disk[p]);
         for (int i = 0; i < per_phase; i++) begin
            if (i % 30 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            if (issued >= total - 150) begin
               calm = 1'b1;
            end
            if (i == per_phase / 2 && p % 3 == 1) begin
               add_drain();
            end
            fn = $urandom_range(0, MAX_FILES - 1);
            k  = $urandom_range(0, 99);
            r  = $urandom_range(0, 19);
            if (k < 40) begin
               t = cba_pkg::REQ_CREATE;
               if (r == 0) cnt = 0;
               else if (r == 1) cnt = $urandom_range(65, 127);
               else if (r <= 3) cnt = $urandom_range(17, 64);
               else cnt = $urandom_range(1, 8);
            end else if (k < 65) begin
               t   = cba_pkg::REQ_DELETE;
               cnt = $urandom_range(0, 127);
            end else if (k < 95) begin
               t = cba_pkg::REQ_EXTEND;
               if (r == 0) cnt = 0;
               else if (r <= 2) cnt = $urandom_range(9, 127);
               else cnt = $urandom_range(1, 4);
            end else begin
               t   = REQ_RESERVED;
               cnt = $urandom_range(0, 127);
            end
            add_req(t, fn, cnt, calm);
            issued++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (op_q.size() != 0 || answer_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== contiguous_block_allocator.f =====
hw/rtl/cba_pkg.sv
hw/rtl/cba_block_map.sv
hw/rtl/cba_directory.sv
hw/rtl/contiguous_block_allocator.sv
hw/rtl/cba_checker.sv
test/tb_contiguous_block_allocator.sv
